// ===== rtl/tpt_pkg.sv =====
// shared types and constants for the text partition table parser
// no dependencies; imported by every module of the block
package tpt_pkg;

	localparam int SECTOR_BITS   = 9;
	localparam int POS_BITS      = 31;
	localparam int CNT_BITS      = 28;
	localparam int VAL_BITS      = 64;
	localparam int SECT_OFF_BITS = 23;
	localparam int IDX_BITS      = 9;
	localparam int DIGIT_BITS    = 4;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam int IN_DATA_BITS  = 8;
	localparam int IN_USER_BITS  = 2;
	localparam int OUT_USER_BITS = 2;
	localparam int OUT_PAY_BITS  = CNT_BITS + 2 * VAL_BITS + SECT_OFF_BITS + IDX_BITS;
	localparam int OUT_DATA_BITS = ((OUT_PAY_BITS + 7) / 8) * 8;

	typedef enum logic [1:0] {
		KIND_RECORD,
		KIND_VALID_END,
		KIND_NOT_TABLE,
		KIND_READ_ERROR
	} kind_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_DIG_START,
		OP_DIG_END,
		OP_RECORD,
		OP_FINISH,
		OP_ERROR
	} op_t;

	typedef struct packed {
		logic                  restart;
		op_t                   op;
		logic [DIGIT_BITS-1:0] digit;
		logic [POS_BITS-1:0]   line_start;
	} token_t;

	typedef struct packed {
		kind_t                    kind;
		logic [CNT_BITS-1:0]      part_number;
		logic [VAL_BITS-1:0]      part_start;
		logic [VAL_BITS-1:0]      part_length;
		logic [SECT_OFF_BITS-1:0] sector_offset;
		logic [IDX_BITS-1:0]      byte_index;
	} result_t;

	function automatic logic [SECT_OFF_BITS-1:0] sect_off(input logic [POS_BITS-1:0] ls);
		logic [SECT_OFF_BITS-1:0] s;
		s = SECT_OFF_BITS'(ls >> SECTOR_BITS);
		return s + SECT_OFF_BITS'(1);
	endfunction

	function automatic logic [VAL_BITS-1:0] mul10_add(input logic [VAL_BITS-1:0] v,
		input logic [DIGIT_BITS-1:0] d);
		return (v << 3) + (v << 1) + VAL_BITS'(d);
	endfunction

endpackage

// ===== rtl/text_partition_table_parser.sv =====
// Text partition table parser, top level: one table byte per beat in, one
// result per beat out. Sustains one byte per clock; a byte's token is queued,
// then its result is registered for output. The front end classifies
// each byte and feeds a four-entry token queue, the back end does the 64-bit
// multiply-by-ten accumulate and fills the output register, so the input
// keeps flowing while a result waits and stalls only when the queue is full.
// depends on tpt_pkg, tpt_front, tpt_fifo, tpt_back
module text_partition_table_parser (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [tpt_pkg::IN_DATA_BITS-1:0]   s_tdata,  // data_byte
	input  logic [tpt_pkg::IN_USER_BITS-1:0]   s_tuser,  // first_byte, read_error
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// part_number, part_start, part_length, sector_offset, byte_index, zero pad
	output logic [tpt_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	output logic [tpt_pkg::OUT_USER_BITS-1:0]  m_tuser   // kind
);
	import tpt_pkg::*;

	logic    push;
	logic    full;
	token_t  wr_token;
	logic    tok_valid;
	logic    tok_ready;
	token_t  tok;
	result_t res;

	tpt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.data_byte  (s_tdata[7:0]),
		.first_byte (s_tuser[0]),
		.read_error (s_tuser[1]),
		.push       (push),
		.token      (wr_token),
		.full       (full)
	);

	tpt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_token (wr_token),
		.full     (full),
		.rd_valid (tok_valid),
		.rd_ready (tok_ready),
		.rd_token (tok)
	);

	tpt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok       (tok),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = OUT_DATA_BITS'({res.byte_index, res.sector_offset, res.part_length,
		res.part_start, res.part_number});
	assign m_tuser = res.kind;

endmodule

// ===== rtl/tpt_front.sv =====
// front end: accepts table bytes, tracks line syntax and position, emits tokens
// depends on tpt_pkg
module tpt_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          first_byte,
	input  logic                          read_error,
	output logic                          push,
	output tpt_pkg::token_t               token,
	input  logic                          full
);
	import tpt_pkg::*;

	typedef enum logic [2:0] {
		PH_SIG,
		PH_NAME,
		PH_START,
		PH_END,
		PH_DONE
	} phase_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [2:0] SIG_LAST = 3'd4;

	function automatic logic [7:0] sig_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0:    c = 8'h70;
			3'd1:    c = 8'h61;
			3'd2:    c = 8'h72;
			3'd3:    c = 8'h74;
			default: c = CH_SPACE;
		endcase
		return c;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	phase_t              phase_q, ph, nxt_phase;
	logic [2:0]          sig_pos_q, sp, nxt_sp;
	logic                sig_bad_q, bad, nxt_bad;
	logic                name_seen_q, ns, nxt_ns;
	logic [POS_BITS-1:0] byte_pos_q, bp, nxt_bp;
	logic [POS_BITS-1:0] line_start_q, ls, nxt_ls;
	logic                accept;
	op_t                 op;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		ph        = first_byte ? PH_SIG : phase_q;
		sp        = first_byte ? 3'd0 : sig_pos_q;
		bad       = first_byte ? 1'b0 : sig_bad_q;
		ns        = first_byte ? 1'b0 : name_seen_q;
		bp        = first_byte ? '0 : byte_pos_q;
		ls        = first_byte ? '0 : line_start_q;
		nxt_phase = ph;
		nxt_sp    = sp;
		nxt_bad   = bad;
		nxt_ns    = ns;
		nxt_bp    = bp;
		nxt_ls    = ls;
		op        = OP_NOP;
		if (ph == PH_DONE) begin
			op = OP_NOP;
		end else if (read_error) begin
			op        = OP_ERROR;
			nxt_phase = PH_DONE;
		end else begin
			nxt_bp = bp + 1'b1;
			unique case (ph)
				PH_SIG: begin
					nxt_bad = bad | (data_byte != sig_char(sp));
					nxt_sp  = sp + 3'd1;
					if (sp == SIG_LAST) begin
						if (nxt_bad) begin
							op        = OP_FINISH;
							nxt_phase = PH_DONE;
						end else begin
							nxt_phase = PH_NAME;
						end
					end
				end
				PH_NAME: begin
					if (is_alnum(data_byte)) begin
						nxt_ns = 1'b1;
					end else if (data_byte != CH_SPACE || !ns) begin
						op        = OP_FINISH;
						nxt_phase = PH_DONE;
					end else begin
						nxt_phase = PH_START;
					end
				end
				PH_START: begin
					if (is_digit(data_byte)) begin
						op = OP_DIG_START;
					end else if (data_byte != CH_SPACE) begin
						op        = OP_FINISH;
						nxt_phase = PH_DONE;
					end else begin
						nxt_phase = PH_END;
					end
				end
				PH_END: begin
					if (is_digit(data_byte)) begin
						op = OP_DIG_END;
					end else if (data_byte != CH_NL) begin
						op        = OP_FINISH;
						nxt_phase = PH_DONE;
					end else begin
						op        = OP_RECORD;
						nxt_ls    = nxt_bp;
						nxt_phase = PH_SIG;
						nxt_sp    = 3'd0;
						nxt_bad   = 1'b0;
						nxt_ns    = 1'b0;
					end
				end
				default: begin
					nxt_phase = PH_DONE;
				end
			endcase
		end
	end

	assign push             = accept && (first_byte || op != OP_NOP);
	assign token.restart    = first_byte;
	assign token.op         = op;
	assign token.digit      = data_byte[DIGIT_BITS-1:0];
	assign token.line_start = ls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SIG;
			sig_pos_q    <= 3'd0;
			sig_bad_q    <= 1'b0;
			name_seen_q  <= 1'b0;
			byte_pos_q   <= '0;
			line_start_q <= '0;
		end else if (accept) begin
			phase_q      <= nxt_phase;
			sig_pos_q    <= nxt_sp;
			sig_bad_q    <= nxt_bad;
			name_seen_q  <= nxt_ns;
			byte_pos_q   <= nxt_bp;
			line_start_q <= nxt_ls;
		end
	end

endmodule

// ===== rtl/tpt_fifo.sv =====
// short token queue between front end and back end
// depends on tpt_pkg
module tpt_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tpt_pkg::token_t wr_token,
	output logic            full,
	output logic            rd_valid,
	input  logic            rd_ready,
	output tpt_pkg::token_t rd_token
);
	import tpt_pkg::*;

	localparam logic [FIFO_AW:0] COUNT_FULL = (FIFO_AW + 1)'(FIFO_DEPTH);

	token_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               pop;

	assign full     = count_q == COUNT_FULL;
	assign rd_valid = count_q != '0;
	assign rd_token = mem_q[rd_ptr_q];
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_token;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/tpt_back.sv =====
// back end: accumulates start and end values, counts records, builds results
// depends on tpt_pkg
module tpt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tok_valid,
	output logic             tok_ready,
	input  tpt_pkg::token_t  tok,
	output logic             res_valid,
	input  logic             res_ready,
	output tpt_pkg::result_t res
);
	import tpt_pkg::*;

	logic [CNT_BITS-1:0] rec_count_q, rc, nxt_rc;
	logic [VAL_BITS-1:0] start_q, sv, nxt_sv;
	logic [VAL_BITS-1:0] end_q, ev, nxt_ev;
	logic                res_valid_q;
	result_t             res_q, nxt_res;
	logic                pop;
	logic                emit;

	assign tok_ready = !res_valid_q || res_ready;
	assign pop       = tok_valid && tok_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		rc = tok.restart ? '0 : rec_count_q;
		sv = tok.restart ? '0 : start_q;
		ev = tok.restart ? '0 : end_q;
		nxt_rc = rc;
		nxt_sv = sv;
		nxt_ev = ev;
		nxt_res.kind          = KIND_RECORD;
		nxt_res.part_number   = '0;
		nxt_res.part_start    = '0;
		nxt_res.part_length   = '0;
		nxt_res.sector_offset = sect_off(tok.line_start);
		nxt_res.byte_index    = tok.line_start[IDX_BITS-1:0];
		emit                  = 1'b0;
		unique case (tok.op)
			OP_DIG_START: begin
				nxt_sv = mul10_add(sv, tok.digit);
			end
			OP_DIG_END: begin
				nxt_ev = mul10_add(ev, tok.digit);
			end
			OP_RECORD: begin
				emit                = 1'b1;
				nxt_res.part_number = rc;
				nxt_res.part_start  = sv;
				nxt_res.part_length = ev - sv;
				nxt_rc              = rc + 1'b1;
				nxt_sv              = '0;
				nxt_ev              = '0;
			end
			OP_FINISH: begin
				emit = 1'b1;
				if (rc != '0) begin
					nxt_res.kind        = KIND_VALID_END;
					nxt_res.part_number = rc;
				end else begin
					nxt_res.kind = KIND_NOT_TABLE;
				end
			end
			OP_ERROR: begin
				emit         = 1'b1;
				nxt_res.kind = KIND_READ_ERROR;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_count_q <= '0;
			start_q     <= '0;
			end_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop && emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (pop) begin
				rec_count_q <= nxt_rc;
				start_q     <= nxt_sv;
				end_q       <= nxt_ev;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res_q <= nxt_res;
		end
	end

endmodule

// ===== rtl/tpt_checker.sv =====
// port-level checks for the text partition table parser, bound to the top level
// depends on tpt_pkg and text_partition_table_parser
module tpt_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic [tpt_pkg::IN_DATA_BITS-1:0]   s_tdata,
	input logic [tpt_pkg::IN_USER_BITS-1:0]   s_tuser,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [tpt_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	input logic [tpt_pkg::OUT_USER_BITS-1:0]  m_tuser
);
	import tpt_pkg::*;

	localparam int NUM_LO  = 0;
	localparam int ST_LO   = NUM_LO + CNT_BITS;
	localparam int LEN_LO  = ST_LO + VAL_BITS;
	localparam int SECT_LO = LEN_LO + VAL_BITS;

	logic [CNT_BITS-1:0]      num;
	logic [VAL_BITS-1:0]      st;
	logic [VAL_BITS-1:0]      len;
	logic [SECT_OFF_BITS-1:0] sect;

	assign num  = m_tdata[NUM_LO +: CNT_BITS];
	assign st   = m_tdata[ST_LO +: VAL_BITS];
	assign len  = m_tdata[LEN_LO +: VAL_BITS];
	assign sect = m_tdata[SECT_LO +: SECT_OFF_BITS];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_sector: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> sect != '0)
		else $error("sector offset is zero");

	a_status_values: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_RECORD |-> st == '0 && len == '0)
		else $error("status beat carries start or length");

	a_status_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_NOT_TABLE || m_tuser == KIND_READ_ERROR) |-> num == '0)
		else $error("failure status carries a partition count");

endmodule

bind text_partition_table_parser tpt_checker u_tpt_checker (.*);
